>>> design/sil_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sorted insert list.
// No dependencies; used by sil_ctrl, sil_datapath and sorted_insert_list_top.
package sil_pkg;

   localparam int ITEM_W    = 32;
   localparam int ENTRIES_W = 6;
   localparam int STATUS_W  = 3;
   localparam int OP_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 2'd0,
      OP_READ_ASC  = 2'd1,
      OP_READ_DESC = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_INSERTED = 3'd0,
      STS_FULL     = 3'd1,
      STS_DATA     = 3'd2,
      STS_EMPTY    = 3'd3,
      STS_CLEARED  = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      status_type status;
      logic       last;
      logic       insert;
      logic       clear;
      logic       rot_asc;
      logic       rot_desc;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

endpackage

>>> design/sil_datapath.sv
`timescale 1ns / 1ps
// Row of sorted value cells with parallel compare-and-shift insert,
// rotating readout and the result register. Depends on sil_pkg.
module sil_datapath #(
   parameter int CAPACITY = 32,
   parameter int CNT_W    = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sil_pkg::cmd_type                    cmd,
   input  logic signed [sil_pkg::ITEM_W-1:0]   in_value,
   output sil_pkg::dp_status_type              dp_status,
   output logic [CNT_W-1:0]                    count,
   output logic signed [sil_pkg::ITEM_W-1:0]   out_item,
   output sil_pkg::status_type                 out_status,
   output logic                                out_last,
   output logic [sil_pkg::ENTRIES_W-1:0]       out_entries
);

   logic signed [sil_pkg::ITEM_W-1:0] cell_ff [CAPACITY];
   logic signed [sil_pkg::ITEM_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]               occ;
   logic [CAPACITY-1:0]               cmp;
   logic [CAPACITY-1:0]               is_last;
   logic signed [sil_pkg::ITEM_W-1:0] last_val;

   logic [CNT_W-1:0] count_ff, count_in;

   logic signed [sil_pkg::ITEM_W-1:0] item_ff, item_in;
   sil_pkg::status_type               status_ff;
   logic                              last_ff;
   logic [sil_pkg::ENTRIES_W-1:0]     entries_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [sil_pkg::ITEM_W-1:0] ins_w, asc_w, desc_w;

      assign occ[i] = count_ff > CNT_W'(i);
      assign cmp[i] = occ[i] && (cell_ff[i] <= in_value);

      if (i == CAPACITY - 1) begin : g_tail
         assign is_last[i] = occ[i];
         assign asc_w      = is_last[i] ? cell_ff[0] : cell_ff[i];
      end else begin : g_body
         assign is_last[i] = occ[i] && !occ[i+1];
         assign asc_w      = occ[i+1] ? cell_ff[i+1] :
                             (is_last[i] ? cell_ff[0] : cell_ff[i]);
      end

      if (i == 0) begin : g_head
         assign ins_w  = cmp[0] ? cell_ff[0] : in_value;
         assign desc_w = last_val;
      end else begin : g_rest
         assign ins_w  = cmp[i] ? cell_ff[i] : (cmp[i-1] ? in_value : cell_ff[i-1]);
         assign desc_w = occ[i] ? cell_ff[i-1] : cell_ff[i];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            cell_in[i] = ins_w;
         end else if (cmd.rot_asc) begin
            cell_in[i] = asc_w;
         end else if (cmd.rot_desc) begin
            cell_in[i] = desc_w;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // one-hot select of the highest occupied cell
   always_comb begin
      last_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         last_val = last_val | ({sil_pkg::ITEM_W{is_last[i]}} & cell_ff[i]);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      item_in = '0;
      if (cmd.rot_asc) begin
         item_in = cell_ff[0];
      end else if (cmd.rot_desc) begin
         item_in = last_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff    <= item_in;
         status_ff  <= cmd.status;
         last_ff    <= cmd.last;
         entries_ff <= sil_pkg::ENTRIES_W'(count_in);
      end
   end

   assign dp_status.full  = count_ff == CNT_W'(CAPACITY);
   assign dp_status.empty = count_ff == '0;
   assign count           = count_ff;
   assign out_item        = item_ff;
   assign out_status      = status_ff;
   assign out_last        = last_ff;
   assign out_entries     = entries_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !dp_status.full)
      else $error("insert into full store");

endmodule

>>> design/sil_ctrl.sv
`timescale 1ns / 1ps
// Controller: decodes transactions, sequences readout, owns result valid.
// Depends on sil_pkg.
module sil_ctrl #(
   parameter int CNT_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sil_pkg::OP_W-1:0]      req_op,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  sil_pkg::dp_status_type        dp_status,
   input  logic [CNT_W-1:0]              count,
   output sil_pkg::cmd_type              cmd
);

   sil_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               desc_ff, desc_in;
   logic               valid_ff, valid_in;
   logic               slot_free;
   sil_pkg::op_type    op;

   assign slot_free = !valid_ff || rsp_tready;
   assign op        = sil_pkg::op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sil_pkg::ST_IDLE;
         rem_ff   <= '0;
         desc_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         desc_ff  <= desc_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      desc_in    = desc_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sil_pkg::ST_IDLE: begin
            req_tready = slot_free && !reset;
            if (req_tvalid && req_tready) begin
               case (op)
                  sil_pkg::OP_INSERT: begin
                     cmd.load = 1'b1;
                     cmd.last = 1'b1;
                     if (dp_status.full) begin
                        cmd.status = sil_pkg::STS_FULL;
                     end else begin
                        cmd.status = sil_pkg::STS_INSERTED;
                        cmd.insert = 1'b1;
                     end
                  end
                  sil_pkg::OP_CLEAR: begin
                     cmd.load   = 1'b1;
                     cmd.last   = 1'b1;
                     cmd.clear  = 1'b1;
                     cmd.status = sil_pkg::STS_CLEARED;
                  end
                  sil_pkg::OP_READ_ASC, sil_pkg::OP_READ_DESC: begin
                     if (dp_status.empty) begin
                        cmd.load   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.status = sil_pkg::STS_EMPTY;
                     end else begin
                        state_in = sil_pkg::ST_READ;
                        rem_in   = count;
                        desc_in  = op == sil_pkg::OP_READ_DESC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sil_pkg::ST_READ: begin
            if (slot_free) begin
               cmd.load     = 1'b1;
               cmd.status   = sil_pkg::STS_DATA;
               cmd.rot_asc  = !desc_ff;
               cmd.rot_desc = desc_ff;
               cmd.last     = rem_ff == CNT_W'(1);
               rem_in       = rem_ff - CNT_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = sil_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sil_pkg::ST_IDLE;
         end
      endcase
   end

   assign valid_in   = cmd.load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;

   a_read_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == sil_pkg::ST_READ |-> rem_ff != '0)
      else $error("readout with nothing left");

   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == sil_pkg::ST_READ |-> !req_tready)
      else $error("request taken during readout");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !cmd.load)
      else $error("pending result overwritten");

endmodule

>>> design/sorted_insert_list_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload
// req_      in   tdata[31:0] value; tuser[1:0] op
// rsp_      out  tdata[31:0] item, [37:32] entries, [39:38] zero; tuser[2:0] status; tlast
//
// Insert, clear and a read of an empty list each give a single result.
// A read of n stored values gives n results, one per cycle while rsp_tready is high,
// once the request is decoded; each result rotates the cell row by one place.
// Synchronous reset empties the list at once; no clearing pass.
// A held result stalls readout; a new request is taken while the result
// register drains.
// Top level of the sorted insert list. Depends on sil_pkg, sil_ctrl, sil_datapath.
module sorted_insert_list_top #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // item, entries, pad
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PAD_W = 40 - sil_pkg::ITEM_W - sil_pkg::ENTRIES_W;

   sil_pkg::cmd_type                  cmd;
   sil_pkg::dp_status_type            dp_status;
   logic [CNT_W-1:0]                  count;
   logic signed [sil_pkg::ITEM_W-1:0] out_item;
   sil_pkg::status_type               out_status;
   logic [sil_pkg::ENTRIES_W-1:0]     out_entries;

   sil_ctrl #(
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .count      (count),
      .cmd        (cmd)
   );

   sil_datapath #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_value    ($signed(req_tdata)),
      .dp_status   (dp_status),
      .count       (count),
      .out_item    (out_item),
      .out_status  (out_status),
      .out_last    (rsp_tlast),
      .out_entries (out_entries)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, out_entries, out_item};
   assign rsp_tuser = out_status;

endmodule
